@@ hdl/canseg_pkg.sv @@
// shared types and constants for the can fd message segmenter
// no dependencies; imported by canseg_engine and can_fd_message_segmenter_top
`default_nettype none

package canseg_pkg;

   // frame type bytes carried in byte 0 of every frame
   localparam logic [7:0] TYPE_START = 8'h01;
   localparam logic [7:0] TYPE_CONT  = 8'h02;
   localparam logic [7:0] TYPE_END   = 8'h03;

   // frame kind codes on the result channel
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_CONT  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // register map
   localparam int          CSR_ADDR_W    = 3;
   localparam logic        REG_FRAME_ID  = 1'b0;
   localparam logic [28:0] FRAME_ID_RESET = 29'd1536;

   // one result item
   typedef struct packed {
      logic [63:0] frame_word;
      logic [2:0]  word_index;
      logic [1:0]  frame_kind;
      logic [28:0] can_id;
      logic        frame_done;
      logic        message_done;
      logic        run_last;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/canseg_engine.sv @@
// segmenting engine: input item register, frame state and result register
// depends on canseg_pkg
`default_nettype none

module canseg_engine #(
   parameter int FRAME_BYTES = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire [28:0]              frame_id,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire [7:0]               req_data_byte,
   input  wire                     req_has_byte,
   input  wire                     req_message_end,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output canseg_pkg::result_type  rsp_item
);
   import canseg_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam int IDX_W = POS_W - 3;
   localparam logic [POS_W:0]   FRAME_LEN = FRAME_BYTES[POS_W:0];
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'((FRAME_BYTES - 1) / 8);
   localparam logic [POS_W-1:0] HDR_POS   = POS_W'(2);

   typedef enum logic [1:0] {ST_BYTE, ST_PAD_DATA, ST_PAD_END} state_type;

   // registers
   state_type        state_ff, state_in;
   logic             item_valid_ff, item_valid_in;
   logic [7:0]       item_byte_ff, item_byte_in;
   logic             item_has_ff, item_has_in;
   logic             item_end_ff, item_end_in;
   logic [7:0]       seq_ff, seq_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [63:0]      acc_ff, acc_in;
   logic             open_ff, open_in;
   logic             start_sent_ff, start_sent_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic             out_free;
   logic             consume;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !item_valid_ff || consume;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // next state of the frame builder
   always_comb begin
      logic [63:0]      b_acc;
      logic [63:0]      b_word;
      logic [POS_W-1:0] b_pos;
      logic [POS_W:0]   b_inc;
      logic [7:0]       b_seq;
      logic             b_open;
      logic             b_start;
      logic [1:0]       b_kind;
      logic             b_full;
      logic             p_last;

      state_in      = state_ff;
      seq_in        = seq_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      open_in       = open_ff;
      start_sent_in = start_sent_ff;
      consume       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      b_acc   = acc_ff;
      b_word  = 64'd0;
      b_pos   = pos_ff;
      b_inc   = '0;
      b_seq   = seq_ff;
      b_open  = open_ff;
      b_start = start_sent_ff;
      b_kind  = start_sent_ff ? KIND_CONT : KIND_START;
      b_full  = 1'b0;
      p_last  = pos_ff[POS_W-1:3] == LAST_IDX;

      case (state_ff)
         ST_BYTE: begin
            if (item_valid_ff && out_free) begin
               consume = 1'b1;
               if (item_has_ff) begin
                  // open a start or continuation frame with its header
                  if (!open_ff) begin
                     b_acc  = {48'd0, seq_ff, start_sent_ff ? TYPE_CONT : TYPE_START};
                     b_pos  = HDR_POS;
                     b_seq  = seq_ff + 8'd1;
                     b_open = 1'b1;
                  end
                  // place the payload byte, emit on word end or frame end
                  b_word = b_acc | ({56'd0, item_byte_ff} << {b_pos[2:0], 3'b000});
                  b_inc  = {1'b0, b_pos} + 1'b1;
                  b_full = b_inc == FRAME_LEN;
                  if (b_inc[2:0] == 3'd0 || b_full) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.frame_word    = b_word;
                     rsp_in.word_index    = 3'(b_pos[POS_W-1:3]);
                     rsp_in.frame_kind    = b_kind;
                     rsp_in.can_id        = frame_id;
                     rsp_in.frame_done    = b_full;
                     rsp_in.message_done  = 1'b0;
                     rsp_in.run_last      = !item_end_ff;
                     b_acc = 64'd0;
                  end else begin
                     b_acc = b_word;
                  end
                  if (b_full) begin
                     b_open = 1'b0;
                     b_pos  = '0;
                     if (!start_sent_ff) begin
                        b_start = 1'b1;
                     end
                  end else begin
                     b_pos = b_inc[POS_W-1:0];
                  end
               end
               state_in      = ST_BYTE;
               seq_in        = b_seq;
               pos_in        = b_pos;
               acc_in        = b_acc;
               open_in       = b_open;
               start_sent_in = b_start;
               // message end: pad the open frame, or open the needed frame
               if (item_end_ff) begin
                  if (b_open) begin
                     state_in = ST_PAD_DATA;
                  end else if (!b_start) begin
                     acc_in   = {48'd0, b_seq, TYPE_START};
                     pos_in   = HDR_POS;
                     open_in  = 1'b1;
                     seq_in   = b_seq + 8'd1;
                     state_in = ST_PAD_DATA;
                  end else begin
                     acc_in   = {48'd0, b_seq, TYPE_END};
                     pos_in   = HDR_POS;
                     open_in  = 1'b1;
                     state_in = ST_PAD_END;
                  end
               end
            end
         end
         ST_PAD_DATA, ST_PAD_END: begin
            // one zero-padded word per cycle while the result register is free
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.frame_word    = acc_ff;
               rsp_in.word_index    = 3'(pos_ff[POS_W-1:3]);
               rsp_in.frame_kind    = (state_ff == ST_PAD_END) ? KIND_END : b_kind;
               rsp_in.can_id        = frame_id;
               rsp_in.frame_done    = p_last;
               rsp_in.message_done  = p_last && state_ff == ST_PAD_END;
               rsp_in.run_last      = p_last && state_ff == ST_PAD_END;
               acc_in = 64'd0;
               if (!p_last) begin
                  pos_in = {pos_ff[POS_W-1:3] + 1'b1, 3'b000};
               end else if (state_ff == ST_PAD_DATA) begin
                  // data frame closed, end frame follows at once
                  acc_in   = {48'd0, seq_ff, TYPE_END};
                  pos_in   = HDR_POS;
                  open_in  = 1'b1;
                  state_in = ST_PAD_END;
               end else begin
                  // message finished
                  open_in       = 1'b0;
                  pos_in        = '0;
                  seq_in        = 8'd0;
                  start_sent_in = 1'b0;
                  state_in      = ST_BYTE;
               end
            end
         end
         default: begin
            state_in = ST_BYTE;
         end
      endcase
   end

   // input item register
   always_comb begin
      item_valid_in = item_valid_ff && !consume;
      item_byte_in  = item_byte_ff;
      item_has_in   = item_has_ff;
      item_end_in   = item_end_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_byte_in  = req_data_byte;
         item_has_in   = req_has_byte;
         item_end_in   = req_message_end;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_BYTE;
         item_valid_ff <= 1'b0;
         seq_ff        <= 8'd0;
         pos_ff        <= '0;
         acc_ff        <= 64'd0;
         open_ff       <= 1'b0;
         start_sent_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         seq_ff        <= seq_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         open_ff       <= open_in;
         start_sent_ff <= start_sent_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_byte_ff <= item_byte_in;
      item_has_ff  <= item_has_in;
      item_end_ff  <= item_end_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

@@ hdl/can_fd_message_segmenter_top.sv @@
// top level of the can fd message segmenter: register port and engine
// depends on canseg_pkg and canseg_engine
//
// Usage:
//   req_* carries a message one byte per item (has_byte, message_end marks
//   the last byte or, with has_byte low, ends the message without a byte).
//   rsp_* returns 64-bit frame words, one per item, eight per 64-byte frame.
//   csr_* is a register port holding frame_id at byte address 0.
// Path: a word that a byte completes passes the input register, then the
//   result register.
// Throughput: one byte item per cycle while the result side keeps up. A
//   message end runs, on the same condition, one word per cycle: the padding
//   words of the open frame plus the eight of the end frame (up to 16),
//   during which the input register holds one waiting item and then stalls.
// Reset: no frame open, sequence at 0, frame_id back to 0x600, both
//   channels empty.
// Stall: while a held word sees rsp_ready low, the result register keeps it
//   and the engine and input side stop until it is taken.
`default_nettype none

module can_fd_message_segmenter_top #(
   parameter int FRAME_BYTES = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   // register port
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire [canseg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire [31:0]                   csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   // input items
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [7:0]                    req_data_byte,
   input  wire                          req_has_byte,
   input  wire                          req_message_end,
   // result items
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [63:0]                  rsp_frame_word,
   output logic [2:0]                   rsp_word_index,
   output logic [1:0]                   rsp_frame_kind,
   output logic [28:0]                  rsp_can_id,
   output logic                         rsp_frame_done,
   output logic                         rsp_message_done,
   output logic                         rsp_run_last
);
   import canseg_pkg::*;

   logic [28:0] frame_id_ff, frame_id_in;
   logic        csr_write;
   logic        csr_hit;
   result_type  rsp_item;

   // register decode
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == REG_FRAME_ID;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {3'd0, frame_id_ff} : 32'd0;

   always_comb begin
      frame_id_in = frame_id_ff;
      if (csr_write && csr_hit) begin
         frame_id_in = csr_pwdata[28:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff <= FRAME_ID_RESET;
      end else begin
         frame_id_ff <= frame_id_in;
      end
   end

   // segmenting engine
   canseg_engine #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .frame_id        (frame_id_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item        (rsp_item)
   );

   // result fields
   assign rsp_frame_word   = rsp_item.frame_word;
   assign rsp_word_index   = rsp_item.word_index;
   assign rsp_frame_kind   = rsp_item.frame_kind;
   assign rsp_can_id       = rsp_item.can_id;
   assign rsp_frame_done   = rsp_item.frame_done;
   assign rsp_message_done = rsp_item.message_done;
   assign rsp_run_last     = rsp_item.run_last;

endmodule

`default_nettype wire

@@ test/can_fd_message_segmenter_top_test.sv @@
// self-checking testbench for can_fd_message_segmenter_top: frame prediction, driver, monitor
// depends on canseg_pkg and can_fd_message_segmenter_top
module can_fd_message_segmenter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import canseg_pkg::*;

   localparam int FRAME_BYTES = 64;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 10;

   // one input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       message_end;
   } byte_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte = '0;
   logic                  req_has_byte = 1'b0;
   logic                  req_message_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [63:0]           rsp_frame_word;
   logic [2:0]            rsp_word_index;
   logic [1:0]            rsp_frame_kind;
   logic [28:0]           rsp_can_id;
   logic                  rsp_frame_done;
   logic                  rsp_message_done;
   logic                  rsp_run_last;

   can_fd_message_segmenter_top #(.FRAME_BYTES(FRAME_BYTES)) dut (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid), .req_ready(req_ready), .req_data_byte(req_data_byte),
      .req_has_byte(req_has_byte), .req_message_end(req_message_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_frame_word(rsp_frame_word),
      .rsp_word_index(rsp_word_index), .rsp_frame_kind(rsp_frame_kind),
      .rsp_can_id(rsp_can_id), .rsp_frame_done(rsp_frame_done),
      .rsp_message_done(rsp_message_done), .rsp_run_last(rsp_run_last)
   );

   always #1 clock = ~clock;

   // segmenter state as predicted
   logic [28:0] frame_id_now = FRAME_ID_RESET;
   logic [7:0]  next_sequence = '0;
   int          fill_pos = 0;
   logic [63:0] word_bytes = '0;
   bit          frame_is_open = 0;
   bit          start_closed = 0;

   result_type  step_words [16];
   int          step_count;
   result_type  expected_words [$];
   byte_item_type pending_bytes [$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  counted_items = 0;
   bit  req_taken = 0;
   int  send_gap = 0;
   int  recv_wait = 0;
   bit  send_burst = 0;
   bit  recv_burst = 0;
   byte_item_type next_item;
   result_type    want_word;

   // close the word being assembled into a result
   task automatic emit_word(input int word_no, input logic [1:0] kind, input bit fdone,
                            input bit mdone);
      result_type w;
      w.frame_word   = word_bytes;
      w.word_index   = 3'(word_no);
      w.frame_kind   = kind;
      w.can_id       = frame_id_now;
      w.frame_done   = fdone;
      w.message_done = mdone;
      w.run_last     = 1'b0;
      if (step_count < 16) begin
         step_words[step_count] = w;
         step_count++;
      end
      word_bytes = '0;
   endtask

   task automatic place_byte(input logic [7:0] b, input logic [1:0] kind);
      bit full;
      word_bytes = word_bytes | ({56'd0, b} << (8 * (fill_pos % 8)));
      fill_pos++;
      full = fill_pos >= FRAME_BYTES;
      if (fill_pos % 8 == 0 || full)
         emit_word((fill_pos - 1) / 8, kind, full, full && kind == KIND_END);
      if (full) begin
         frame_is_open = 0;
         fill_pos = 0;
         if (kind == KIND_START)
            start_closed = 1;
      end
   endtask

   task automatic open_frame(input logic [1:0] kind, input logic [7:0] type_byte,
                             input logic [7:0] seq);
      frame_is_open = 1;
      fill_pos = 0;
      word_bytes = '0;
      place_byte(type_byte, kind);
      place_byte(seq, kind);
   endtask

   task automatic pad_frame(input logic [1:0] kind);
      while (frame_is_open)
         place_byte(8'h00, kind);
   endtask

   // work out the frame words that one accepted item causes
   task automatic predict_frames(input byte_item_type it);
      logic [7:0] seq;
      step_count = 0;
      if (it.has_byte) begin
         if (!frame_is_open) begin
            seq = next_sequence;
            next_sequence = next_sequence + 8'd1;
            if (start_closed)
               open_frame(KIND_CONT, TYPE_CONT, seq);
            else
               open_frame(KIND_START, TYPE_START, seq);
         end
         place_byte(it.data_byte, start_closed ? KIND_CONT : KIND_START);
      end
      if (it.message_end) begin
         if (frame_is_open) begin
            pad_frame(start_closed ? KIND_CONT : KIND_START);
         end else if (!start_closed) begin
            // empty message still gets a start frame
            seq = next_sequence;
            next_sequence = next_sequence + 8'd1;
            open_frame(KIND_START, TYPE_START, seq);
            pad_frame(KIND_START);
         end
         open_frame(KIND_END, TYPE_END, next_sequence);
         pad_frame(KIND_END);
         next_sequence = '0;
         start_closed = 0;
      end
      if (step_count > 0)
         step_words[step_count - 1].run_last = 1'b1;
      for (int i = 0; i < step_count; i++)
         expected_words.insert(expected_words.size(), step_words[i]);
   endtask

   task automatic check_field(input string field_name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, field_name, want, got);
         mismatch_count++;
      end
   endtask

   // idle-length draws, with stretches of back-to-back traffic
   function automatic int draw_wait(inout bit burst);
      if ($urandom_range(0, 19) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(0, 7);
   endfunction

   // accept items on the input side and predict their words
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         next_item.data_byte   = req_data_byte;
         next_item.has_byte    = req_has_byte;
         next_item.message_end = req_message_end;
         predict_frames(next_item);
         req_taken = 1;
      end
   end

   // input driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_item = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_item.data_byte;
            req_has_byte <= next_item.has_byte;
            req_message_end <= next_item.message_end;
            send_gap = draw_wait(send_burst);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word: expected none actual %h", $time, rsp_frame_word);
            mismatch_count++;
         end else begin
            want_word = expected_words.pop_front();
            check_field("frame_word", want_word.frame_word, rsp_frame_word);
            check_field("word_index", 64'(want_word.word_index), 64'(rsp_word_index));
            check_field("frame_kind", 64'(want_word.frame_kind), 64'(rsp_frame_kind));
            check_field("can_id", 64'(want_word.can_id), 64'(rsp_can_id));
            check_field("frame_done", 64'(want_word.frame_done), 64'(rsp_frame_done));
            check_field("message_done", 64'(want_word.message_done),
                        64'(rsp_message_done));
            check_field("run_last", 64'(want_word.run_last), 64'(rsp_run_last));
         end
         recv_wait = draw_wait(recv_burst);
      end
   end

   // result-side stalls
   always @(negedge clock) begin
      if (recv_wait > 0) begin
         recv_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_words.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_item(input logic [7:0] data, input bit has, input bit msg_end);
      byte_item_type it;
      it.data_byte   = data;
      it.has_byte    = has;
      it.message_end = msg_end;
      pending_bytes.insert(pending_bytes.size(), it);
      if (has || msg_end)
         counted_items++;
   endtask

   // a message of len bytes with random content and occasional idle items
   task automatic queue_message(input int len);
      bit end_on_byte;
      end_on_byte = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            queue_item(8'($urandom_range(0, 255)), 0, 0);
         queue_item(8'($urandom_range(0, 255)), 1, end_on_byte && i == len - 1);
      end
      if (len == 0 || !end_on_byte)
         queue_item(8'($urandom_range(0, 255)), 0, 1);
   endtask

   // wait until everything sent has come back and the engine has settled
   task automatic wait_drained;
      while (pending_bytes.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_id(input logic [28:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * REG_FRAME_ID);
      csr_pwdata <= {3'b000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      frame_id_now = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      logic [28:0] phase_ids [4];
      int          pick;
      int          len;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle items, empty message, single bytes at both extremes,
      // end without a byte after an open frame, a word filled exactly
      queue_item(8'h00, 0, 0);
      queue_item(8'hFF, 0, 0);
      queue_item(8'h5A, 0, 1);
      queue_item(8'hFF, 1, 1);
      queue_item(8'h00, 1, 0);
      queue_item(8'h00, 0, 0);
      queue_item(8'hA5, 1, 0);
      queue_item(8'hFF, 0, 1);
      queue_item(8'h00, 1, 1);
      for (int i = 0; i < 6; i++)
         queue_item(8'(8'h11 * (i + 1)), 1, i == 5);
      queue_item(8'h00, 0, 1);
      queue_item(8'hFF, 0, 1);
      wait_drained();

      // random phases, each under its own identifier; every phase but the
      // last may leave a message open so the next one continues it
      phase_ids[0] = 29'h1FFFFFFF;
      phase_ids[1] = 29'h0;
      phase_ids[2] = 29'($urandom_range(0, 32'h1FFFFFFF));
      phase_ids[3] = 29'($urandom_range(0, 32'h7FF));
      for (int p = 0; p < 4; p++) begin
         write_frame_id(phase_ids[p]);
         counted_items = 0;
         while (counted_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
               // empty message, or a start frame just short of, at, or past full
               pick = $urandom_range(0, 3);
               case (pick)
                  0: len = 0;
                  1: len = FRAME_BYTES - 3;
                  2: len = FRAME_BYTES - 2;
                  default: len = FRAME_BYTES - 1;
               endcase
            end else begin
               len = $urandom_range(1, 20);
            end
            queue_message(len);
         end
         if (p < 3) begin
            len = $urandom_range(0, 20);
            for (int i = 0; i < len; i++)
               queue_item(8'($urandom_range(0, 255)), 1, 0);
         end
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
